### design/tmbg_pkg.sv
// ----------------------------------------------------------------------------
// tmbg_pkg: shared types and constants of the battery gauge
// Command and status structs between controller and datapath, register
// indexes, reset values and level mapping constants.
// ----------------------------------------------------------------------------
package tmbg_pkg;

  localparam int WinLen = 10;
  localparam int IdxW   = 4;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(WinLen - 1);

  localparam logic [1:0] CFG_EMPTY   = 2'd0;
  localparam logic [1:0] CFG_FULL    = 2'd1;
  localparam logic [1:0] CFG_STEP    = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  localparam logic [15:0] EmptyReset   = 16'd1700;
  localparam logic [15:0] FullReset    = 16'd2050;
  localparam logic [15:0] StepReset    = 16'd35;
  localparam logic [7:0]  TimeoutReset = 8'd20;

  localparam logic [3:0] QMax      = 4'd10;
  localparam logic [6:0] LevelMax  = 7'd100;
  localparam logic [6:0] LevelStep = 7'd10;
  localparam logic [7:0] TicksMax  = 8'd255;

  typedef struct packed {
    logic            load;
    logic            scan_en;
    logic [IdxW-1:0] scan_idx;
    logic            map_en;
    logic            class_en;
    logic            div_en;
    logic            out_load;
  } tmbg_cmd_t;

  typedef struct packed {
    logic div_done;
  } tmbg_sts_t;

endpackage

### design/tmbg_ctrl.sv
// ----------------------------------------------------------------------------
// tmbg_ctrl: sequencer of the battery gauge
// Steps the datapath through window scan, averaging, classification and the
// level quotient, and owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module tmbg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tmbg_pkg::tmbg_sts_t sts_i,
  output tmbg_pkg::tmbg_cmd_t cmd_o
);
  import tmbg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MAP   = 6'b000100,
    S_CLASS = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.scan_idx = idx_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        idx_d         = idx_q + 1'b1;
        if (idx_q == IdxLast) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map_en = 1'b1;
        state_d      = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.class_en = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The result register may still hold the previous item.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/tmbg_dp.sv
// ----------------------------------------------------------------------------
// tmbg_dp: datapath of the battery gauge
// Sample window, sum/max/min accumulator, trimmed mean, level quotient by
// bounded repeated subtraction, idle tick counter and configuration registers.
// ----------------------------------------------------------------------------
module tmbg_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        sample_i,
  input  logic               activity_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  tmbg_pkg::tmbg_cmd_t cmd_i,
  output tmbg_pkg::tmbg_sts_t sts_o,
  output logic [6:0]         level_o,
  output logic               low_battery_o,
  output logic [15:0]        average_o,
  output logic               backlight_off_o
);
  import tmbg_pkg::*;

  localparam int SumW = SAMPLE_BITS + 4;

  logic [SAMPLE_BITS-1:0] win_q [WinLen];
  logic [SumW-1:0]        sum_q;
  logic [SAMPLE_BITS-1:0] hi_q, lo_q, avg_q;
  logic [15:0]            rem_q;
  logic [3:0]             quo_q;
  logic                   below_q, above_q;

  logic [15:0] empty_q, full_q, step_q;
  logic [7:0]  timeout_q;
  logic [7:0]  ticks_q, ticks_d;
  logic        flag_q, flag_d;

  logic [6:0]  level_q;
  logic        low_q, bl_q;
  logic [15:0] avg_out_q;

  logic [SAMPLE_BITS-1:0] scan_v;
  logic [SumW-1:0]        trimmed;
  logic [15:0]            avg16;
  logic                   div_fit;
  logic [6:0]             level_c;
  logic [7:0]             ticks_base;

  assign scan_v  = win_q[cmd_i.scan_idx];
  assign trimmed = sum_q - SumW'(hi_q) - SumW'(lo_q);
  assign avg16   = 16'(avg_q);
  assign div_fit = (rem_q >= step_q) && (quo_q < QMax);
  assign sts_o.div_done = below_q || above_q || !div_fit;

  always_comb begin
    if (below_q) begin
      level_c = '0;
    end else if (above_q) begin
      level_c = LevelMax;
    end else begin
      level_c = 7'(quo_q) * LevelStep;
    end
  end

  // Activity clears the counter and flag before this tick is counted.
  always_comb begin
    ticks_base = activity_i ? '0 : ticks_q;
    ticks_d    = (ticks_base < TicksMax) ? ticks_base + 1'b1 : ticks_base;
    flag_d     = (activity_i ? 1'b0 : flag_q) || (ticks_d > timeout_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= '0;
      end
      ticks_q   <= '0;
      flag_q    <= 1'b0;
      empty_q   <= EmptyReset;
      full_q    <= FullReset;
      step_q    <= StepReset;
      timeout_q <= TimeoutReset;
    end else begin
      if (cmd_i.load) begin
        for (int i = 0; i < WinLen - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WinLen-1] <= sample_i[SAMPLE_BITS-1:0];
        ticks_q <= ticks_d;
        flag_q  <= flag_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_EMPTY:   empty_q   <= cfg_data_i;
          CFG_FULL:    full_q    <= cfg_data_i;
          CFG_STEP:    step_q    <= cfg_data_i;
          CFG_TIMEOUT: timeout_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q <= '0;
      hi_q  <= '0;
      lo_q  <= '1;
    end
    if (cmd_i.scan_en) begin
      sum_q <= sum_q + SumW'(scan_v);
      if (scan_v > hi_q) begin
        hi_q <= scan_v;
      end
      if (scan_v < lo_q) begin
        lo_q <= scan_v;
      end
    end
    if (cmd_i.map_en) begin
      avg_q <= trimmed[SAMPLE_BITS+2:3];
    end
    if (cmd_i.class_en) begin
      below_q <= avg16 < empty_q;
      above_q <= avg16 > full_q;
      rem_q   <= avg16 - empty_q;
      quo_q   <= '0;
    end
    // A zero step always fits, so the quotient runs to its cap of ten.
    if (cmd_i.div_en && div_fit) begin
      rem_q <= rem_q - step_q;
      quo_q <= quo_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      level_q   <= level_c;
      low_q     <= (level_c == '0);
      avg_out_q <= avg16;
      bl_q      <= flag_q;
    end
  end

  assign level_o         = level_q;
  assign low_battery_o   = low_q;
  assign average_o       = avg_out_q;
  assign backlight_off_o = bl_q;

endmodule

### design/trimmed_mean_battery_gauge_top.sv
// ----------------------------------------------------------------------------
// trimmed_mean_battery_gauge_top: trimmed-mean battery gauge
// Ten-sample window filter, level mapping and backlight idle timer.
// ----------------------------------------------------------------------------
// Each accepted item passes through the ten-entry window scan, averaging,
// classification and the level quotient (up to ten subtract steps).
// The gauge holds one item at a time; the next item is taken the cycle
// after a result is loaded, even while that result waits on out_ready_i.
// Reset: asynchronous, active low; clears the window, idle counter and flag,
// and loads the register defaults.
module trimmed_mean_battery_gauge_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  input  logic        activity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  level_o,
  output logic        low_battery_o,
  output logic [15:0] average_o,
  output logic        backlight_off_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tmbg_pkg::*;

  tmbg_cmd_t cmd;
  tmbg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tmbg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tmbg_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_i        (sample_i),
    .activity_i      (activity_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .level_o         (level_o),
    .low_battery_o   (low_battery_o),
    .average_o       (average_o),
    .backlight_off_o (backlight_off_o)
  );

endmodule

### design/tmbg_checker.sv
// ----------------------------------------------------------------------------
// tmbg_checker: port-level checks of the battery gauge
// Watches the top level's handshakes and result fields over time.
// ----------------------------------------------------------------------------
module tmbg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] level_o,
  input logic       low_battery_o,
  input logic [15:0] average_o,
  input logic       backlight_off_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o)
      && $stable(average_o) && $stable(backlight_off_o))
    else $error("stalled result changed");

  a_low_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (low_battery_o == (level_o == 7'd0)))
    else $error("low_battery disagrees with level");

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= 7'd100)
    else $error("level above one hundred");

  // The gauge works on one item at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

endmodule

bind trimmed_mean_battery_gauge_top tmbg_checker u_tmbg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .level_o         (level_o),
  .low_battery_o   (low_battery_o),
  .average_o       (average_o),
  .backlight_off_o (backlight_off_o)
);
